>>> hdl/prc_pkg.sv
// Shared types and constants for the pair result cache with lifetime expiry.
// Used by the top level pair_result_cache_ttl; the channel interfaces do not use it.
package prc_pkg;

	localparam int SLOTS_DEF = 256;
	localparam int NUM_CNT   = 7;

	// Counter positions inside the statistics bank.
	localparam int CNT_HIT    = 0;
	localparam int CNT_MISS   = 1;
	localparam int CNT_COLL   = 2;
	localparam int CNT_EXP    = 3;
	localparam int CNT_STORE  = 4;
	localparam int CNT_REPL   = 5;
	localparam int CNT_RECOMP = 6;

	localparam logic [31:0] TTL_RST  = 32'd1000;
	localparam logic [31:0] HASH_MUL = 32'h9E37_79B1;
	localparam logic [31:0] HASH_ADD = 32'h85EB_CA6B;

	typedef enum logic [1:0] {
		CMD_LOOKUP    = 2'd0,
		CMD_STORE     = 2'd1,
		CMD_RECOMPUTE = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_HIT      = 3'd0,
		ST_REJECTED = 3'd1,
		ST_EMPTY    = 3'd2,
		ST_COLL     = 3'd3,
		ST_EXPIRED  = 3'd4,
		ST_STORED   = 3'd5,
		ST_REPLACED = 3'd6,
		ST_DONE     = 3'd7
	} status_t;

	typedef struct packed {
		logic        vld;
		logic [63:0] key_lo;
		logic [63:0] key_hi;
		logic [31:0] stamp;
		logic        value;
	} entry_t;

	typedef struct packed {
		logic        hit;
		logic        hit_value;
		status_t     status;
		logic [31:0] hit_count;
		logic [31:0] miss_count;
		logic [31:0] collision_count;
		logic [31:0] expired_count;
		logic [31:0] store_count;
		logic [31:0] replace_count;
		logic [31:0] recompute_count;
	} result_t;

	function automatic logic [31:0] fold64(input logic [63:0] v);
		return v[63:32] ^ v[31:0];
	endfunction

endpackage

>>> hdl/prc_in_if.sv
// Request channel of the pair result cache: valid/ready handshake and one item.
// Stands alone; no package dependency.
interface prc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] key_a;
	logic [63:0] key_b;
	logic [31:0] now;
	logic        store_value;

	modport source (output valid, cmd, key_a, key_b, now, store_value, input ready);
	modport sink   (input valid, cmd, key_a, key_b, now, store_value, output ready);
endinterface

>>> hdl/prc_out_if.sv
// Result channel of the pair result cache: valid/ready handshake and one result.
// Stands alone; no package dependency.
interface prc_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic        hit_value;
	logic [2:0]  status;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] collision_count;
	logic [31:0] expired_count;
	logic [31:0] store_count;
	logic [31:0] replace_count;
	logic [31:0] recompute_count;

	modport source (output valid, hit, hit_value, status, hit_count, miss_count,
		collision_count, expired_count, store_count, replace_count, recompute_count,
		input ready);
	modport sink   (input valid, hit, hit_value, status, hit_count, miss_count,
		collision_count, expired_count, store_count, replace_count, recompute_count,
		output ready);
endinterface

>>> hdl/pair_result_cache_ttl.sv
// Top level of the pair result cache with lifetime expiry.
// Depends on prc_pkg, prc_in_if and prc_out_if.
//
// Usage: requests arrive on req (valid/ready), one result per request leaves
// on rsp (valid/ready). cfg_we/cfg_wdata write the entry lifetime; write it
// only while the block is idle.
// From acceptance to the result register an item passes the input register, the
// hash register (order, fold and multiply), then the table read whose data is
// resolved against the key, counted and written back in the last stage.
// One item per cycle unless a stall, clear or sweep holds intake; a write to the
// table in the last stage is forwarded to a read of the same slot on the same edge.
// A clear command stops intake until it has drained and the table sweep
// (one slot per cycle through the single write port) is over.
// After reset the same sweep runs before the first item is taken;
// counters start at zero and the lifetime at 1000 ticks.
// When the receiver stalls, the whole pipeline holds and req.ready drops, so
// up to four items wait inside (three stages and the result register);
// nothing is lost or repeated.
module pair_result_cache_ttl #(
	parameter int SLOTS = prc_pkg::SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	prc_in_if.sink            req,
	prc_out_if.source         rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [AW-1:0] SLOT_MASK = AW'(SLOTS - 1);

	// Control state.
	logic              vld_s1, vld_s2, vld_s3, out_vld_q;
	logic              sweep_q;
	logic [AW-1:0]     sweep_idx_q;
	logic [31:0]       ttl_q;
	logic [31:0]       cnt_q [prc_pkg::NUM_CNT];
	logic              fwd_vld_q;

	// Payload state.
	prc_pkg::cmd_t     cmd_s1, cmd_s2, cmd_s3;
	logic [63:0]       a_s1, b_s1;
	logic [63:0]       lo_s2, hi_s2, lo_s3, hi_s3;
	logic [31:0]       now_s1, now_s2, now_s3;
	logic              sv_s1, sv_s2, sv_s3;
	logic              rej_s2, rej_s3;
	logic [31:0]       h_s2, y_s2;
	logic [AW-1:0]     slot_s3;
	prc_pkg::entry_t   rd_s3;
	prc_pkg::entry_t   fwd_data_q;
	logic [AW-1:0]     fwd_slot_q;
	prc_pkg::result_t  rsp_q;
	prc_pkg::entry_t   mem [SLOTS];

	logic              adv, commit, clr_pending;
	logic              swap1, rej1;
	logic [63:0]       lo1, hi1;
	logic [31:0]       t2, hx2;
	logic [AW-1:0]     slot2;
	prc_pkg::entry_t   ent3, new_ent3;
	logic              same3, wr3;
	logic [31:0]       age3;
	logic [31:0]       cnt_d [prc_pkg::NUM_CNT];
	prc_pkg::result_t  res3;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	prc_pkg::entry_t   mem_wdata;

	assign adv    = !out_vld_q || rsp.ready;
	assign commit = adv && vld_s3;

	// A clear runs alone through the pipeline so no item reads the table mid-sweep.
	assign clr_pending = (vld_s1 && cmd_s1 == prc_pkg::CMD_CLEAR)
		|| (vld_s2 && cmd_s2 == prc_pkg::CMD_CLEAR)
		|| (vld_s3 && cmd_s3 == prc_pkg::CMD_CLEAR);

	assign req.ready = adv && !sweep_q && !clr_pending;

	// Stage 1 to 2: order the pair, flag rejects, fold and multiply.
	always_comb begin
		swap1 = b_s1 < a_s1;
		lo1   = swap1 ? b_s1 : a_s1;
		hi1   = swap1 ? a_s1 : b_s1;
		rej1  = (a_s1 == 64'd0) || (b_s1 == 64'd0)
			|| (cmd_s1 == prc_pkg::CMD_LOOKUP && ttl_q == 32'd0);
	end

	// Stage 2: finish the hash and form the table address.
	always_comb begin
		t2    = y_s2 + prc_pkg::HASH_ADD + {h_s2[25:0], 6'd0} + {2'd0, h_s2[31:2]};
		hx2   = h_s2 ^ t2;
		slot2 = hx2[AW-1:0] & SLOT_MASK;
	end

	// Stage 3: resolve the entry, update counters and form the result.
	always_comb begin
		ent3  = (fwd_vld_q && fwd_slot_q == slot_s3) ? fwd_data_q : rd_s3;
		same3 = (ent3.key_lo == lo_s3) && (ent3.key_hi == hi_s3);
		age3  = now_s3 - ent3.stamp;
		wr3   = 1'b0;
		for (int i = 0; i < prc_pkg::NUM_CNT; i++) begin
			cnt_d[i] = cnt_q[i];
		end
		res3.hit       = 1'b0;
		res3.hit_value = 1'b0;
		res3.status    = prc_pkg::ST_DONE;
		new_ent3.vld    = 1'b1;
		new_ent3.key_lo = lo_s3;
		new_ent3.key_hi = hi_s3;
		new_ent3.stamp  = now_s3;
		new_ent3.value  = sv_s3;
		if (vld_s3) begin
			unique case (cmd_s3)
				prc_pkg::CMD_LOOKUP: begin
					if (rej_s3) begin
						res3.status = prc_pkg::ST_REJECTED;
					end else if (!ent3.vld) begin
						cnt_d[prc_pkg::CNT_MISS] = cnt_q[prc_pkg::CNT_MISS] + 32'd1;
						res3.status = prc_pkg::ST_EMPTY;
					end else if (!same3) begin
						cnt_d[prc_pkg::CNT_MISS] = cnt_q[prc_pkg::CNT_MISS] + 32'd1;
						cnt_d[prc_pkg::CNT_COLL] = cnt_q[prc_pkg::CNT_COLL] + 32'd1;
						res3.status = prc_pkg::ST_COLL;
					end else if (age3 >= ttl_q) begin
						cnt_d[prc_pkg::CNT_MISS] = cnt_q[prc_pkg::CNT_MISS] + 32'd1;
						cnt_d[prc_pkg::CNT_EXP]  = cnt_q[prc_pkg::CNT_EXP] + 32'd1;
						res3.status = prc_pkg::ST_EXPIRED;
					end else begin
						cnt_d[prc_pkg::CNT_HIT] = cnt_q[prc_pkg::CNT_HIT] + 32'd1;
						res3.hit       = 1'b1;
						res3.hit_value = ent3.value;
						res3.status    = prc_pkg::ST_HIT;
					end
				end
				prc_pkg::CMD_STORE: begin
					if (rej_s3) begin
						res3.status = prc_pkg::ST_REJECTED;
					end else begin
						wr3 = 1'b1;
						cnt_d[prc_pkg::CNT_STORE] = cnt_q[prc_pkg::CNT_STORE] + 32'd1;
						if (ent3.vld && !same3) begin
							cnt_d[prc_pkg::CNT_REPL] = cnt_q[prc_pkg::CNT_REPL] + 32'd1;
							res3.status = prc_pkg::ST_REPLACED;
						end else begin
							res3.status = prc_pkg::ST_STORED;
						end
					end
				end
				prc_pkg::CMD_RECOMPUTE: begin
					cnt_d[prc_pkg::CNT_RECOMP] = cnt_q[prc_pkg::CNT_RECOMP] + 32'd1;
				end
				prc_pkg::CMD_CLEAR: begin
					for (int i = 0; i < prc_pkg::NUM_CNT; i++) begin
						cnt_d[i] = 32'd0;
					end
				end
				default: begin
					res3.status = prc_pkg::ST_DONE;
				end
			endcase
		end
		res3.hit_count       = cnt_d[prc_pkg::CNT_HIT];
		res3.miss_count      = cnt_d[prc_pkg::CNT_MISS];
		res3.collision_count = cnt_d[prc_pkg::CNT_COLL];
		res3.expired_count   = cnt_d[prc_pkg::CNT_EXP];
		res3.store_count     = cnt_d[prc_pkg::CNT_STORE];
		res3.replace_count   = cnt_d[prc_pkg::CNT_REPL];
		res3.recompute_count = cnt_d[prc_pkg::CNT_RECOMP];
	end

	// The sweep and stage 3 never write in the same cycle.
	always_comb begin
		mem_we    = sweep_q || (commit && wr3);
		mem_waddr = sweep_q ? sweep_idx_q : slot_s3;
		mem_wdata = sweep_q ? '0 : new_ent3;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_s3 <= mem[slot2];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			out_vld_q   <= 1'b0;
			sweep_q     <= 1'b1;
			sweep_idx_q <= '0;
			ttl_q       <= prc_pkg::TTL_RST;
			fwd_vld_q   <= 1'b0;
			for (int i = 0; i < prc_pkg::NUM_CNT; i++) begin
				cnt_q[i] <= 32'd0;
			end
		end else begin
			if (cfg_we) begin
				ttl_q <= cfg_wdata;
			end
			if (adv) begin
				vld_s1    <= req.valid && req.ready;
				vld_s2    <= vld_s1;
				vld_s3    <= vld_s2;
				out_vld_q <= vld_s3;
				fwd_vld_q <= commit && wr3;
			end
			if (commit) begin
				for (int i = 0; i < prc_pkg::NUM_CNT; i++) begin
					cnt_q[i] <= cnt_d[i];
				end
			end
			if (sweep_q) begin
				if (sweep_idx_q == SLOT_MASK) begin
					sweep_q <= 1'b0;
				end else begin
					sweep_idx_q <= sweep_idx_q + AW'(1);
				end
			end else if (commit && cmd_s3 == prc_pkg::CMD_CLEAR) begin
				sweep_q     <= 1'b1;
				sweep_idx_q <= '0;
			end
		end
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= prc_pkg::cmd_t'(req.cmd);
			a_s1   <= req.key_a;
			b_s1   <= req.key_b;
			now_s1 <= req.now;
			sv_s1  <= req.store_value;
		end
		if (adv) begin
			cmd_s2  <= cmd_s1;
			lo_s2   <= lo1;
			hi_s2   <= hi1;
			now_s2  <= now_s1;
			sv_s2   <= sv_s1;
			rej_s2  <= rej1;
			h_s2    <= 32'(prc_pkg::fold64(lo1) * prc_pkg::HASH_MUL);
			y_s2    <= prc_pkg::fold64(hi1);
			cmd_s3  <= cmd_s2;
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
			now_s3  <= now_s2;
			sv_s3   <= sv_s2;
			rej_s3  <= rej_s2;
			slot_s3 <= slot2;
		end
		if (commit) begin
			rsp_q      <= res3;
			fwd_data_q <= new_ent3;
			fwd_slot_q <= slot_s3;
		end
	end

	assign rsp.valid           = out_vld_q;
	assign rsp.hit             = rsp_q.hit;
	assign rsp.hit_value       = rsp_q.hit_value;
	assign rsp.status          = rsp_q.status;
	assign rsp.hit_count       = rsp_q.hit_count;
	assign rsp.miss_count      = rsp_q.miss_count;
	assign rsp.collision_count = rsp_q.collision_count;
	assign rsp.expired_count   = rsp_q.expired_count;
	assign rsp.store_count     = rsp_q.store_count;
	assign rsp.replace_count   = rsp_q.replace_count;
	assign rsp.recompute_count = rsp_q.recompute_count;

	a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !req.ready)
		else $error("item taken while the table sweep runs");

	a_clear_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && cmd_s3 == prc_pkg::CMD_CLEAR) |-> (!vld_s1 && !vld_s2))
		else $error("item follows a clear inside the pipeline");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp.valid)
		else $error("finished item did not reach the result register");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.hit == (rsp.status == prc_pkg::ST_HIT)))
		else $error("hit flag disagrees with status");

endmodule
